// File: rtl/olte_pkg.sv
package olte_pkg;

    // Input commands carried in s_tuser
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_ENTRY = 2'd1,
        CMD_FRAME = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    // Stream widths
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 40;

    // Position and address constants
    localparam logic [7:0]  MIRROR_BASE       = 8'd248;
    localparam logic [7:0]  SPRITE_YTOP       = 8'd240;
    localparam logic [7:0]  COLUMN_YTOP       = 8'd0;
    localparam logic [7:0]  CHAIN_STEP        = 8'd16;
    localparam logic [12:0] COLUMN_BASE_WORD  = 13'h200;
    localparam logic [5:0]  LAST_SPRITE_TILE  = 6'd3;
    localparam logic [5:0]  LAST_COLUMN_TILE  = 6'd63;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic take;
        logic run;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic entry_live;
        logic drained;
    } dp_status_t;

endpackage

// File: rtl/object_list_tile_emitter_top.sv
// Write and frame-start transactions and empty entries leave the block idle.
// A non-empty entry gives 4 tiles (sprite) or 64 tiles (column), one per cycle while
// m_tready does not stall, from a two-stage read pipeline; the next transaction is
// accepted once every tile is issued and the read stage is empty.
// Reset: synchronous, active low; it then clears the tile RAM, both byte banks in step,
// before s_tready rises.
module object_list_tile_emitter_top #(
    parameter int RAM_DEPTH = 16384
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // ram_address[13:0], ram_byte[21:14], entry_vertical[29:22], entry_number[37:30],
    // entry_horizontal[45:38], entry_attribute[53:46], zero fill[55:54]
    input  logic [olte_pkg::IN_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [1:0]                       s_tuser,
    // Flip register write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,
    // Tile stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tile_code[13:0], palette[17:14], pos_x[25:18], pos_y[33:26], mirrored[34],
    // zero fill[39:35]
    output logic [olte_pkg::OUT_TDATA_W-1:0] m_tdata,
    // last_tile
    output logic                             m_tlast
);
    import olte_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    olte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    olte_dpath #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // No input transaction while the tile RAM is being cleared
    a_no_take_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.clear_en && s_tready))
        else $error("input taken during RAM clear");

    // A non-empty entry blocks the input on the following cycle
    a_entry_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && status.entry_live |=> !s_tready)
        else $error("input ready right after a live entry");

    // Leaving reset always starts with the clearing pass
    a_reset_clears: assert property (@(posedge aclk)
        $rose(aresetn) |-> (cmd.clear_en && !s_tready))
        else $error("clearing pass not running after reset");
`endif

endmodule

// File: rtl/olte_ram.sv
module olte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while re is low
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/olte_ctrl.sv
module olte_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  olte_pkg::dp_status_t status,
    output olte_pkg::ctrl_cmd_t  cmd
);
    import olte_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands from the current state
    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.take     = s_tvalid && s_tready;
    assign cmd.clear_en = (state_reg == ST_CLEAR);
    assign cmd.run      = (state_reg == ST_EMIT);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd.take && status.entry_live) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.drained) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/olte_dpath.sv
module olte_dpath #(
    parameter int RAM_DEPTH = 16384
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  olte_pkg::ctrl_cmd_t                 cmd,
    output olte_pkg::dp_status_t                status,
    input  logic [olte_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [1:0]                          s_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [olte_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tlast
);
    import olte_pkg::*;

    localparam int EVEN_DEPTH = (RAM_DEPTH + 1) / 2;
    localparam int ODD_DEPTH  = RAM_DEPTH / 2;
    localparam int EAW        = $clog2(EVEN_DEPTH);
    localparam int OAW        = $clog2(ODD_DEPTH);

    // Input fields
    logic [13:0] ram_address;
    logic [7:0]  ram_byte;
    logic [7:0]  entry_vertical;
    logic [7:0]  entry_number;
    logic [7:0]  entry_horizontal;
    logic [7:0]  entry_attribute;

    assign ram_address      = s_tdata[13:0];
    assign ram_byte         = s_tdata[21:14];
    assign entry_vertical   = s_tdata[29:22];
    assign entry_number     = s_tdata[37:30];
    assign entry_horizontal = s_tdata[45:38];
    assign entry_attribute  = s_tdata[53:46];

    logic is_write;
    logic is_frame;
    logic load_entry;
    logic wr_hit;

    assign is_write   = (s_tuser == CMD_WRITE);
    assign is_frame   = (s_tuser == CMD_FRAME);
    assign status.entry_live = (s_tuser == CMD_ENTRY) && (|s_tdata[53:22]);
    assign load_entry = cmd.take && status.entry_live;
    assign wr_hit     = cmd.take && is_write && ({18'd0, ram_address} < 32'(RAM_DEPTH));

    // Flip register, written any time
    logic flip_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            flip_reg <= cfg_data;
        end
    end

    // Clearing sweep over both banks after reset
    logic [EAW-1:0] clr_cnt_reg;
    assign status.clear_last = (clr_cnt_reg == EAW'(EVEN_DEPTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Bank write ports: even bytes and odd bytes
    logic           even_we;
    logic           odd_we;
    logic [EAW-1:0] even_waddr;
    logic [OAW-1:0] odd_waddr;
    logic [7:0]     bank_wdata;

    assign even_we    = cmd.clear_en || (wr_hit && !ram_address[0]);
    assign odd_we     = cmd.clear_en
                        ? ({{(32-EAW){1'b0}}, clr_cnt_reg} < 32'(ODD_DEPTH))
                        : (wr_hit && ram_address[0]);
    assign even_waddr = cmd.clear_en ? clr_cnt_reg : EAW'(ram_address[13:1]);
    assign odd_waddr  = cmd.clear_en ? OAW'(clr_cnt_reg) : OAW'(ram_address[13:1]);
    assign bank_wdata = cmd.clear_en ? 8'd0 : ram_byte;

    // Entry registers
    logic [7:0]  running_x_reg;
    logic [7:0]  running_x_next;
    logic [12:0] base_word_reg;
    logic [7:0]  ytop_reg;
    logic [3:0]  attr_reg;
    logic        column_reg;
    logic [5:0]  last_cnt_reg;
    logic [12:0] base_word_next;

    assign base_word_next = entry_number[7]
                            ? ({1'b0, entry_number[5:0], 6'd0} + COLUMN_BASE_WORD)
                            : {4'd0, entry_number[6:0], 2'b00};

    // Update running X on frame start and on non-empty entries
    always_comb begin
        running_x_next = running_x_reg;
        if (cmd.take && is_frame) begin
            running_x_next = 8'd0;
        end else if (load_entry) begin
            if (entry_number[7] && entry_number[6]) begin
                running_x_next = running_x_reg + CHAIN_STEP;
            end else begin
                running_x_next = entry_horizontal;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_x_reg <= 8'd0;
        end else begin
            running_x_reg <= running_x_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_entry) begin
            base_word_reg <= base_word_next;
            ytop_reg      <= (entry_number[7] ? COLUMN_YTOP : SPRITE_YTOP) - entry_vertical;
            attr_reg      <= entry_attribute[3:0];
            column_reg    <= entry_number[7];
            last_cnt_reg  <= entry_number[7] ? LAST_COLUMN_TILE : LAST_SPRITE_TILE;
        end
    end

    // Tile sequencer
    logic [5:0] cnt_reg;
    logic       issued_all_reg;
    logic       advance;
    logic       issue;
    logic       s1_valid_reg;

    assign advance = !m_tvalid || m_tready;
    assign issue   = cmd.run && !issued_all_reg && advance;
    assign status.drained = issued_all_reg && !s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issued_all_reg <= 1'b1;
            cnt_reg        <= 6'd0;
        end else if (load_entry) begin
            issued_all_reg <= 1'b0;
            cnt_reg        <= 6'd0;
        end else if (issue) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == last_cnt_reg) begin
                issued_all_reg <= 1'b1;
            end
        end
    end

    // Tile position and read address for the current count
    logic        half;
    logic [4:0]  row;
    logic [7:0]  tile_x;
    logic [7:0]  tile_y;
    logic [12:0] rd_word;

    assign half    = column_reg ? cnt_reg[5] : cnt_reg[1];
    assign row     = column_reg ? cnt_reg[4:0] : {4'd0, cnt_reg[0]};
    assign tile_x  = running_x_reg + {4'd0, half, 3'd0};
    assign tile_y  = ytop_reg + {row, 3'd0};
    assign rd_word = base_word_reg + {7'd0, cnt_reg};

    logic [7:0] lo_byte;
    logic [7:0] hi_byte;

    olte_ram #(
        .WIDTH (8),
        .DEPTH (EVEN_DEPTH)
    ) u_even_ram (
        .aclk  (aclk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (bank_wdata),
        .re    (advance),
        .raddr (EAW'(rd_word)),
        .rdata (lo_byte)
    );

    olte_ram #(
        .WIDTH (8),
        .DEPTH (ODD_DEPTH)
    ) u_odd_ram (
        .aclk  (aclk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (bank_wdata),
        .re    (advance),
        .raddr (OAW'(rd_word)),
        .rdata (hi_byte)
    );

    // Read stage: position data alongside the RAM read
    logic [7:0] s1_x_reg;
    logic [7:0] s1_y_reg;
    logic       s1_last_reg;
    logic [3:0] s1_attr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_x_reg    <= flip_reg ? (MIRROR_BASE - tile_x) : tile_x;
            s1_y_reg    <= flip_reg ? (MIRROR_BASE - tile_y) : tile_y;
            s1_last_reg <= (cnt_reg == last_cnt_reg);
            s1_attr_reg <= attr_reg;
        end
    end

    // Output register
    logic        out_valid_reg;
    logic [13:0] out_code_reg;
    logic [3:0]  out_pal_reg;
    logic [7:0]  out_x_reg;
    logic [7:0]  out_y_reg;
    logic        out_mirror_reg;
    logic        out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_code_reg   <= {hi_byte[5:0], lo_byte};
            out_pal_reg    <= {2'b00, hi_byte[7:6]} | s1_attr_reg;
            out_x_reg      <= s1_x_reg;
            out_y_reg      <= s1_y_reg;
            out_mirror_reg <= flip_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_mirror_reg, out_y_reg, out_x_reg, out_pal_reg, out_code_reg};

endmodule
